[hdl/sosm_pkg.sv]
// ----------------------------------------------------------------------------
// sosm_pkg: shared types and constants for the shift-or substring matcher
// Mask word layout, request codes, register indexes and the case fold.
// ----------------------------------------------------------------------------
package sosm_pkg;

  localparam int MAX_PATTERN = 64;             // mask word width in bits
  localparam int VEC_W       = MAX_PATTERN;
  localparam int TABLE_DEPTH = 256;            // one word per byte value
  localparam int ADDR_W      = 8;
  localparam int POS_W       = 6;              // pattern_pos field width
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = 7;              // pattern_length register width
  localparam int OFF_W       = 32;             // byte offset width
  localparam int OUT_W       = 32;             // reported offset width
  localparam int REQ_W       = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TEXT  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLD_CASE      = 1'd1;

  localparam logic [VEC_W-1:0] VEC_ONES = {VEC_W{1'b1}};

  typedef logic [VEC_W-1:0]  vec_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // mask table write / clear port
  typedef struct packed {
    logic  en;
    addr_t addr;
    vec_t  data;
    logic  clr;
  } mem_wr_t;

  // per-word command into the scan engine
  typedef struct packed {
    logic step;     // text byte completes this cycle
    logic restart;  // clear request: restart text state
    logic last;     // text byte ends the text
  } scan_cmd_t;

  // ASCII upper to lower when folding is on
  function automatic addr_t fold_byte(input logic [7:0] c, input logic ic);
    addr_t r;
    r = c;
    if (ic && (c >= 8'h41) && (c <= 8'h5A)) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

[hdl/shift_or_substring_matcher.sv]
// ----------------------------------------------------------------------------
// shift_or_substring_matcher: shift-or (bitap) exact substring matcher
// Mask table in RAM, one request word per cycle unless stalled, first match per text.
// ----------------------------------------------------------------------------
// Usage: load a pattern with one clear word followed by one load word per
// pattern character (bit pattern_pos is cleared in the mask word of that
// character), set pattern_length and case folding through the config port,
// then stream text bytes. Every text byte returns exactly one result word;
// clear, load and unused request codes return none. The block takes one
// request word per cycle, back to back, unless input stall is raised; a
// text byte's result moves from stage 1 into the output register. The rate
// is set by the single mask table read port: each word does one read at
// accept time and its read-modify-write (load) or recurrence step (text)
// in stage 1; a load immediately followed by a lookup of the same entry is
// served by a write bypass in the RAM wrapper. A clear drops all entry valid
// bits at once, so there is no clearing pass after reset. Input stall
// is raised only while a text result cannot move into a stalled, full output
// register. Only the first match of a text is reported; text_last restarts
// the match vector, offset and found flag after that byte's result.
// ----------------------------------------------------------------------------
module shift_or_substring_matcher (
  input  logic                              clk,
  input  logic                              rst,
  // config
  input  logic                              cfg_we,
  input  logic [sosm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sosm_pkg::CFG_DATA_W-1:0]   cfg_data,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sosm_pkg::REQ_W-1:0]        req_type,
  input  logic [7:0]                        char_byte,
  input  logic [sosm_pkg::POS_W-1:0]        pattern_pos,
  input  logic                              text_last,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              match_found,
  output logic [sosm_pkg::OUT_W-1:0]        match_start,
  output logic [sosm_pkg::OUT_W-1:0]        match_end,
  output logic                              any_match,
  output logic                              text_end
);

  // config registers
  logic [sosm_pkg::LEN_W-1:0] pattern_length;
  logic                       fold_case;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      fold_case      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sosm_pkg::CFG_PATTERN_LENGTH: pattern_length <= cfg_data[sosm_pkg::LEN_W-1:0];
        sosm_pkg::CFG_FOLD_CASE:      fold_case      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage 1: word whose mask read is in flight
  logic                        s1_valid;
  logic [sosm_pkg::REQ_W-1:0]  s1_req;
  sosm_pkg::addr_t             s1_addr;
  logic [sosm_pkg::POS_W-1:0]  s1_pos;
  logic                        s1_last;

  logic                s1_go;
  logic                accept;
  sosm_pkg::addr_t     raddr;
  sosm_pkg::vec_t      entry;
  sosm_pkg::mem_wr_t   wr;
  sosm_pkg::scan_cmd_t cmd;
  sosm_pkg::vec_t      pos_bit;

  // a text word can only retire if the result register is free or draining
  assign s1_go    = s1_valid && ((s1_req != sosm_pkg::REQ_TEXT) || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;
  assign accept   = in_valid && !in_stall;
  assign raddr    = sosm_pkg::fold_byte(char_byte, fold_case);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req  <= req_type;
      s1_addr <= raddr;
      s1_pos  <= pattern_pos;
      s1_last <= text_last;
    end
  end

  // load: clear the position bit in the current mask word
  always_comb begin
    pos_bit = sosm_pkg::vec_t'(1) << s1_pos;
    wr.en   = s1_go && (s1_req == sosm_pkg::REQ_LOAD) &&
              ({1'b0, s1_pos} < (sosm_pkg::POS_W + 1)'(sosm_pkg::MAX_PATTERN));
    wr.addr = s1_addr;
    wr.data = entry & ~pos_bit;
    wr.clr  = s1_go && (s1_req == sosm_pkg::REQ_CLEAR);

    cmd.step    = s1_go && (s1_req == sosm_pkg::REQ_TEXT);
    cmd.restart = wr.clr;
    cmd.last    = s1_last;
  end

  sosm_mask_mem u_mask_mem (
    .clk   (clk),
    .rst   (rst),
    .re    (accept),
    .raddr (raddr),
    .wr    (wr),
    .rdata (entry)
  );

  sosm_scan u_scan (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .mask           (entry),
    .pattern_length (pattern_length),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .match_found    (match_found),
    .match_start    (match_start),
    .match_end      (match_end),
    .any_match      (any_match),
    .text_end       (text_end)
  );

endmodule

[hdl/sosm_mask_mem.sv]
// ----------------------------------------------------------------------------
// sosm_mask_mem: mask word table
// 256 x MAX_PATTERN synchronous RAM, registered read, per-entry valid bits
// so a clear empties it at once; same-cycle write to read address bypassed.
// ----------------------------------------------------------------------------
module sosm_mask_mem (
  input  logic             clk,
  input  logic             rst,
  input  logic             re,
  input  sosm_pkg::addr_t  raddr,
  input  sosm_pkg::mem_wr_t wr,
  output sosm_pkg::vec_t   rdata
);

  sosm_pkg::vec_t mem [sosm_pkg::TABLE_DEPTH];
  logic [sosm_pkg::TABLE_DEPTH-1:0] valid;

  sosm_pkg::vec_t mem_q;
  sosm_pkg::vec_t byp_data;
  logic           byp;
  logic           vld_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.clr) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      mem_q    <= mem[raddr];
      byp      <= wr.en && (wr.addr == raddr);
      byp_data <= wr.data;
      vld_q    <= valid[raddr] && !wr.clr;
    end
  end

  // unwritten entries read as all ones
  assign rdata = byp ? byp_data : (vld_q ? mem_q : sosm_pkg::VEC_ONES);

endmodule

[hdl/sosm_scan.sv]
// ----------------------------------------------------------------------------
// sosm_scan: shift-or recurrence and result register
// Holds match vector, byte offset and found flag; forms one result per byte.
// ----------------------------------------------------------------------------
module sosm_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  sosm_pkg::scan_cmd_t          cmd,
  input  sosm_pkg::vec_t               mask,
  input  logic [sosm_pkg::LEN_W-1:0]   pattern_length,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic                         match_found,
  output logic [sosm_pkg::OUT_W-1:0]   match_start,
  output logic [sosm_pkg::OUT_W-1:0]   match_end,
  output logic                         any_match,
  output logic                         text_end
);

  sosm_pkg::vec_t              d;
  logic [sosm_pkg::OFF_W-1:0]  offset;
  logic                        found;

  sosm_pkg::vec_t              d_next;
  logic [sosm_pkg::LEN_W-1:0]  len;
  logic [sosm_pkg::LEN_W-1:0]  len_m1;
  logic [sosm_pkg::OFF_W-1:0]  off_inc;
  logic                        hit;

  always_comb begin
    if (pattern_length > sosm_pkg::LEN_W'(sosm_pkg::MAX_PATTERN)) begin
      len = sosm_pkg::LEN_W'(sosm_pkg::MAX_PATTERN);
    end else begin
      len = pattern_length;
    end
    len_m1  = len - 1'b1;
    d_next  = {d[sosm_pkg::VEC_W-2:0], 1'b0} | mask;
    off_inc = offset + 1'b1;
    hit     = !found && ((len == '0) || !d_next[len_m1[sosm_pkg::IDX_W-1:0]]);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      d      <= sosm_pkg::VEC_ONES;
      offset <= '0;
      found  <= 1'b0;
    end else if (cmd.step) begin
      if (cmd.last) begin
        d      <= sosm_pkg::VEC_ONES;
        offset <= '0;
        found  <= 1'b0;
      end else begin
        d      <= d_next;
        offset <= off_inc;
        found  <= found | hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      match_found <= hit;
      any_match   <= found | hit;
      text_end    <= cmd.last;
      if (hit && (len != '0)) begin
        match_end   <= sosm_pkg::OUT_W'(off_inc);
        match_start <= sosm_pkg::OUT_W'(off_inc - sosm_pkg::OFF_W'(len));
      end else begin
        match_end   <= '0;
        match_start <= '0;
      end
    end
  end

endmodule
